@@ rtl/pjd_pkg.sv @@
// Package for the priority job dispatcher: sizes, codes, beat and storage types.
package pjd_pkg;

  localparam int JOB_SLOTS   = 128;
  localparam int WORKERS     = 5;
  localparam int MAX_RESULTS = 5;

  localparam int IDX_W  = $clog2(JOB_SLOTS);
  localparam int CNT_W  = $clog2(JOB_SLOTS + 1);
  localparam int WIDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int WID_W  = $clog2(WORKERS + 1);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W = 11;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ASSIGN = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_ASSIGNED  = 3'd1,
    KIND_COMPLETED = 3'd2,
    KIND_REJECTED  = 3'd3,
    KIND_NONE      = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_CMP,
    ST_ADD_INS,
    ST_ASG,
    ST_TICK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] customer_id;
    logic [9:0]  prep_time;
    logic [9:0]  distance;
    logic [7:0]  priority_req;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        order_id;
    logic [15:0]       customer_id_res;
    logic [2:0]        worker_id;
    logic [TIME_W-1:0] total_time;
    logic              last;
  } out_beat_t;

  typedef struct packed {
    logic [CNT_W-1:0]  id;
    logic [15:0]       cust;
    logic [TIME_W-1:0] work;
    logic [7:0]        prio;
    logic              waiting;
  } job_t;

  typedef struct packed {
    logic              busy;
    logic [CNT_W-1:0]  id;
    logic [15:0]       cust;
    logic [TIME_W-1:0] work;
    logic [TIME_W-1:0] remain;
  } worker_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } push_t;

endpackage

@@ rtl/pjd_job_ram.sv @@
// Job table memory: one write port and one registered read port.
module pjd_job_ram (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [pjd_pkg::IDX_W-1:0] wr_addr,
  input  pjd_pkg::job_t           wr_data,
  input  logic [pjd_pkg::IDX_W-1:0] rd_addr,
  output pjd_pkg::job_t           rd_data
);

  pjd_pkg::job_t mem [pjd_pkg::JOB_SLOTS];
  pjd_pkg::job_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/pjd_ctrl.sv @@
// Command sequencer: table insertion walk, assign walk, worker tick walk and result staging.
module pjd_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  pjd_pkg::in_beat_t         in_data,
  input  logic                      out_free,
  output pjd_pkg::push_t            push,
  output logic                      wr_en,
  output logic [pjd_pkg::IDX_W-1:0] wr_addr,
  output pjd_pkg::job_t             wr_data,
  output logic [pjd_pkg::IDX_W-1:0] rd_addr,
  input  pjd_pkg::job_t             rd_data
);

  pjd_pkg::state_t                  state_r, state_nxt;
  pjd_pkg::in_beat_t                item_r, item_nxt;
  logic [pjd_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [pjd_pkg::IDX_W-1:0]        pos_r, pos_nxt;
  logic [pjd_pkg::RES_W-1:0]        n_r, n_nxt;
  logic [pjd_pkg::WIDX_W-1:0]       w_r, w_nxt;
  logic                             pend_valid_r, pend_valid_nxt;
  pjd_pkg::out_beat_t               pend_r, pend_nxt;
  pjd_pkg::worker_t                 wrk_r [pjd_pkg::WORKERS];
  pjd_pkg::worker_t                 wrk_nxt [pjd_pkg::WORKERS];

  pjd_pkg::job_t                    new_job;
  logic                             idle_found;
  logic [pjd_pkg::WIDX_W-1:0]       idle_idx;
  pjd_pkg::worker_t                 cur;
  logic                             last_step;

  // The job being added, built from the held item.
  always_comb begin
    new_job.id      = count_r + pjd_pkg::CNT_W'(1);
    new_job.cust    = item_r.customer_id;
    new_job.work    = pjd_pkg::TIME_W'(item_r.prep_time) + pjd_pkg::TIME_W'(item_r.distance);
    new_job.prio    = item_r.priority_req;
    new_job.waiting = 1'b1;
  end

  // Lowest-numbered idle worker.
  always_comb begin
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int w = pjd_pkg::WORKERS - 1; w >= 0; w--) begin
      if (!wrk_r[w].busy) begin
        idle_found = 1'b1;
        idle_idx   = pjd_pkg::WIDX_W'(w);
      end
    end
  end

  assign cur = wrk_r[w_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pjd_pkg::ST_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      n_r          <= '0;
      for (int w = 0; w < pjd_pkg::WORKERS; w++) begin
        wrk_r[w] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      n_r          <= n_nxt;
      for (int w = 0; w < pjd_pkg::WORKERS; w++) begin
        wrk_r[w] <= wrk_nxt[w];
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    pos_r  <= pos_nxt;
    w_r    <= w_nxt;
    pend_r <= pend_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    n_nxt          = n_r;
    w_nxt          = w_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    for (int w = 0; w < pjd_pkg::WORKERS; w++) begin
      wrk_nxt[w] = wrk_r[w];
    end
    wr_en     = 1'b0;
    wr_addr   = pos_r;
    wr_data   = new_job;
    rd_addr   = pos_r;
    push      = '0;
    in_stall  = 1'b1;
    last_step = 1'b0;

    case (state_r)
      pjd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          item_nxt       = in_data;
          pend_valid_nxt = 1'b0;
          n_nxt          = '0;
          state_nxt      = pjd_pkg::ST_DECODE;
        end
      end

      pjd_pkg::ST_DECODE: begin
        case (item_r.command)
          pjd_pkg::CMD_ADD: begin
            if (count_r == pjd_pkg::CNT_W'(pjd_pkg::JOB_SLOTS)) begin
              pend_valid_nxt = 1'b1;
              pend_nxt       = '0;
              pend_nxt.kind  = pjd_pkg::KIND_REJECTED;
              state_nxt      = pjd_pkg::ST_FIN;
            end else if (count_r == '0) begin
              pos_nxt   = '0;
              state_nxt = pjd_pkg::ST_ADD_INS;
            end else begin
              pos_nxt   = pjd_pkg::IDX_W'(count_r);
              rd_addr   = pjd_pkg::IDX_W'(count_r - pjd_pkg::CNT_W'(1));
              state_nxt = pjd_pkg::ST_ADD_CMP;
            end
          end
          pjd_pkg::CMD_ASSIGN: begin
            pos_nxt = '0;
            rd_addr = '0;
            if (count_r == '0) begin
              state_nxt = pjd_pkg::ST_FIN;
            end else begin
              state_nxt = pjd_pkg::ST_ASG;
            end
          end
          pjd_pkg::CMD_TICK: begin
            w_nxt     = '0;
            state_nxt = pjd_pkg::ST_TICK;
          end
          default: begin
            state_nxt = pjd_pkg::ST_FIN;
          end
        endcase
      end

      // rd_data holds the entry just above the insertion point.
      pjd_pkg::ST_ADD_CMP: begin
        wr_en = 1'b1;
        if (rd_data.prio < item_r.priority_req) begin
          wr_data = rd_data;
          pos_nxt = pos_r - pjd_pkg::IDX_W'(1);
          if (pos_r == pjd_pkg::IDX_W'(1)) begin
            state_nxt = pjd_pkg::ST_ADD_INS;
          end else begin
            rd_addr = pos_r - pjd_pkg::IDX_W'(2);
          end
        end else begin
          count_nxt         = count_r + pjd_pkg::CNT_W'(1);
          pend_valid_nxt    = 1'b1;
          pend_nxt          = '0;
          pend_nxt.kind     = pjd_pkg::KIND_ADDED;
          pend_nxt.order_id = 8'(new_job.id);
          state_nxt         = pjd_pkg::ST_FIN;
        end
      end

      pjd_pkg::ST_ADD_INS: begin
        wr_en             = 1'b1;
        count_nxt         = count_r + pjd_pkg::CNT_W'(1);
        pend_valid_nxt    = 1'b1;
        pend_nxt          = '0;
        pend_nxt.kind     = pjd_pkg::KIND_ADDED;
        pend_nxt.order_id = 8'(new_job.id);
        state_nxt         = pjd_pkg::ST_FIN;
      end

      // rd_data holds table entry pos_r.
      pjd_pkg::ST_ASG: begin
        if (rd_data.waiting && idle_found && pend_valid_r && !out_free) begin
          rd_addr = pos_r;
        end else begin
          if (rd_data.waiting && idle_found) begin
            if (pend_valid_r) begin
              push.valid = 1'b1;
              push.beat  = pend_r;
            end
            pend_valid_nxt           = 1'b1;
            pend_nxt                 = '0;
            pend_nxt.kind            = pjd_pkg::KIND_ASSIGNED;
            pend_nxt.order_id        = 8'(rd_data.id);
            pend_nxt.worker_id       = 3'(pjd_pkg::WID_W'(idle_idx) + pjd_pkg::WID_W'(1));
            pend_nxt.total_time      = rd_data.work;
            wrk_nxt[idle_idx].busy   = 1'b1;
            wrk_nxt[idle_idx].id     = rd_data.id;
            wrk_nxt[idle_idx].cust   = rd_data.cust;
            wrk_nxt[idle_idx].work   = rd_data.work;
            wrk_nxt[idle_idx].remain = rd_data.work;
            wr_en                    = 1'b1;
            wr_data                  = rd_data;
            wr_data.waiting          = 1'b0;
            n_nxt                    = n_r + pjd_pkg::RES_W'(1);
          end
          if (n_nxt == pjd_pkg::RES_W'(pjd_pkg::MAX_RESULTS) ||
              pjd_pkg::CNT_W'(pos_r) + pjd_pkg::CNT_W'(1) == count_r) begin
            state_nxt = pjd_pkg::ST_FIN;
          end else begin
            pos_nxt = pos_r + pjd_pkg::IDX_W'(1);
            rd_addr = pos_r + pjd_pkg::IDX_W'(1);
          end
        end
      end

      pjd_pkg::ST_TICK: begin
        last_step = (w_r == pjd_pkg::WIDX_W'(pjd_pkg::WORKERS - 1));
        if (cur.busy && cur.remain <= pjd_pkg::TIME_W'(1) &&
            n_r < pjd_pkg::RES_W'(pjd_pkg::MAX_RESULTS) && pend_valid_r && !out_free) begin
          last_step = 1'b0;
        end else begin
          if (cur.busy) begin
            if (cur.remain > pjd_pkg::TIME_W'(1)) begin
              wrk_nxt[w_r].remain = cur.remain - pjd_pkg::TIME_W'(1);
            end else if (n_r >= pjd_pkg::RES_W'(pjd_pkg::MAX_RESULTS)) begin
              wrk_nxt[w_r].remain = '0;
            end else begin
              if (pend_valid_r) begin
                push.valid = 1'b1;
                push.beat  = pend_r;
              end
              pend_valid_nxt           = 1'b1;
              pend_nxt                 = '0;
              pend_nxt.kind            = pjd_pkg::KIND_COMPLETED;
              pend_nxt.order_id        = 8'(cur.id);
              pend_nxt.customer_id_res = cur.cust;
              pend_nxt.worker_id       = 3'(pjd_pkg::WID_W'(w_r) + pjd_pkg::WID_W'(1));
              pend_nxt.total_time      = cur.work;
              wrk_nxt[w_r]             = '0;
              n_nxt                    = n_r + pjd_pkg::RES_W'(1);
            end
          end
          if (last_step) begin
            state_nxt = pjd_pkg::ST_FIN;
          end else begin
            w_nxt = w_r + pjd_pkg::WIDX_W'(1);
          end
        end
      end

      pjd_pkg::ST_FIN: begin
        if (out_free) begin
          push.valid = 1'b1;
          if (pend_valid_r) begin
            push.beat = pend_r;
          end else begin
            push.beat      = '0;
            push.beat.kind = pjd_pkg::KIND_NONE;
          end
          push.beat.last = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = pjd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pjd_pkg::ST_IDLE;
      end
    endcase
  end

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> out_free) else $error("result pushed into a full output register");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pjd_pkg::CNT_W'(pjd_pkg::JOB_SLOTS)) else $error("job count beyond table");

  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= pjd_pkg::RES_W'(pjd_pkg::MAX_RESULTS)) else $error("too many results for one command");

  a_early_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && !push.beat.last) |->
      (state_r == pjd_pkg::ST_ASG || state_r == pjd_pkg::ST_TICK))
    else $error("non-final result outside a walk");

endmodule

@@ rtl/priority_job_dispatcher_top.sv @@
// Top level of the priority job dispatcher: sequencer, job table memory and output register.
// The dispatcher takes one command beat at a time and stalls its input until every result beat
// of that command has been handed to the output register. An add walks the sorted job table from
// the tail toward the head through the single table read port, one entry per cycle. An assign walks
// the table from the head, one entry per cycle except while a result waits for the output register,
// and stops after the last job or after MAX_RESULTS assignments. A tick visits the workers one per
// cycle except while a result waits for the output register. Results are staged one deep inside
// the sequencer so that the final beat of a command can carry last; a stalled output holds the walk.
// The table needs no clearing after reset, since only entries below the job count are read.
module priority_job_dispatcher_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pjd_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pjd_pkg::out_beat_t out_data
);

  pjd_pkg::push_t            push;
  logic                      out_free;
  logic                      wr_en;
  logic [pjd_pkg::IDX_W-1:0] wr_addr;
  logic [pjd_pkg::IDX_W-1:0] rd_addr;
  pjd_pkg::job_t             wr_data;
  pjd_pkg::job_t             rd_data;

  logic                      out_valid_r;
  pjd_pkg::out_beat_t        out_data_r;

  // The output register can take a new beat when empty or when its beat leaves this cycle.
  assign out_free = !out_valid_r || !out_stall;

  pjd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_free (out_free),
    .push     (push),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  pjd_job_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_data_r <= push.beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ dv/pjd_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the priority job dispatcher: predicts result beats and compares them.
module pjd_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  pjd_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  pjd_pkg::out_beat_t out_data,
  output int                 fail_count,
  output int                 pending_count
);

  localparam logic [1:0] JS_WAIT = 2'd0;
  localparam logic [1:0] JS_ASSIGNED = 2'd1;
  localparam logic [1:0] JS_DONE = 2'd2;

  typedef struct {
    int unsigned id;
    int unsigned cust;
    int unsigned work;
    int unsigned prio;
    logic [1:0]  status;
  } job_rec_t;

  typedef struct {
    bit          busy;
    int unsigned job;
    int unsigned remain;
  } crew_rec_t;

  job_rec_t           jobs[pjd_pkg::JOB_SLOTS];
  crew_rec_t          crew[pjd_pkg::WORKERS];
  int unsigned        njobs;
  pjd_pkg::out_beat_t expected_beats[$];

  function automatic pjd_pkg::out_beat_t make_beat(pjd_pkg::kind_t k, int unsigned id,
                                                   int unsigned cust, int unsigned w,
                                                   int unsigned t);
    pjd_pkg::out_beat_t b;
    b.kind = k;
    b.order_id = id[7:0];
    b.customer_id_res = cust[15:0];
    b.worker_id = w[2:0];
    b.total_time = t[pjd_pkg::TIME_W-1:0];
    b.last = 1'b0;
    return b;
  endfunction

  // Advances the dispatcher state by one command and queues the beats it causes.
  task automatic dispatch_predict(pjd_pkg::in_beat_t c);
    pjd_pkg::out_beat_t res[$];
    int unsigned pos;
    int unsigned prio;
    job_rec_t e;
    pjd_pkg::out_beat_t b;
    if (c.command == pjd_pkg::CMD_ADD) begin
      if (njobs >= pjd_pkg::JOB_SLOTS) begin
        res.push_back(make_beat(pjd_pkg::KIND_REJECTED, 0, 0, 0, 0));
      end else begin
        prio = c.priority_req;
        e.id = njobs + 1;
        e.cust = c.customer_id;
        e.work = c.prep_time + c.distance;
        e.prio = prio;
        e.status = JS_WAIT;
        pos = njobs;
        while (pos > 0 && jobs[pos-1].prio < prio) begin
          jobs[pos] = jobs[pos-1];
          pos--;
        end
        jobs[pos] = e;
        njobs++;
        res.push_back(make_beat(pjd_pkg::KIND_ADDED, e.id, 0, 0, 0));
      end
    end else if (c.command == pjd_pkg::CMD_ASSIGN) begin
      for (int i = 0; i < njobs && res.size() < pjd_pkg::MAX_RESULTS; i++) begin
        if (jobs[i].status != JS_WAIT) continue;
        for (int w = 0; w < pjd_pkg::WORKERS; w++) begin
          if (!crew[w].busy) begin
            crew[w].busy = 1'b1;
            crew[w].job = jobs[i].id;
            crew[w].remain = jobs[i].work;
            jobs[i].status = JS_ASSIGNED;
            res.push_back(make_beat(pjd_pkg::KIND_ASSIGNED, jobs[i].id, 0, w + 1,
                                    jobs[i].work));
            break;
          end
        end
      end
    end else if (c.command == pjd_pkg::CMD_TICK) begin
      for (int w = 0; w < pjd_pkg::WORKERS; w++) begin
        int unsigned cust;
        int unsigned t;
        cust = 0;
        t = 0;
        if (!crew[w].busy) continue;
        if (crew[w].remain > 1) begin
          crew[w].remain--;
          continue;
        end
        if (res.size() >= pjd_pkg::MAX_RESULTS) begin
          crew[w].remain = 0;
          continue;
        end
        for (int k = 0; k < njobs; k++) begin
          if (jobs[k].id == crew[w].job) begin
            jobs[k].status = JS_DONE;
            cust = jobs[k].cust;
            t = jobs[k].work;
            break;
          end
        end
        res.push_back(make_beat(pjd_pkg::KIND_COMPLETED, crew[w].job, cust, w + 1, t));
        crew[w].busy = 1'b0;
        crew[w].job = 0;
        crew[w].remain = 0;
      end
    end
    if (res.size() == 0) res.push_back(make_beat(pjd_pkg::KIND_NONE, 0, 0, 0, 0));
    res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_beats.push_back(res[i]);
  endtask

  task automatic compare_beat(pjd_pkg::out_beat_t got);
    pjd_pkg::out_beat_t want;
    if (expected_beats.size() == 0) begin
      $error("unexpected result beat %p", got);
      fail_count++;
      return;
    end
    want = expected_beats.pop_front();
    if (got.kind != want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      fail_count++;
    end
    if (got.order_id != want.order_id) begin
      $error("order_id: expected %0d, got %0d", want.order_id, got.order_id);
      fail_count++;
    end
    if (got.customer_id_res != want.customer_id_res) begin
      $error("customer_id_res: expected %0d, got %0d", want.customer_id_res,
             got.customer_id_res);
      fail_count++;
    end
    if (got.worker_id != want.worker_id) begin
      $error("worker_id: expected %0d, got %0d", want.worker_id, got.worker_id);
      fail_count++;
    end
    if (got.total_time != want.total_time) begin
      $error("total_time: expected %0d, got %0d", want.total_time, got.total_time);
      fail_count++;
    end
    if (got.last != want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    njobs = 0;
    foreach (crew[w]) crew[w] = '{1'b0, 0, 0};
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) compare_beat(out_data);
      if (in_valid && !in_stall) dispatch_predict(in_data);
    end
    pending_count = expected_beats.size();
  end
endmodule

@@ dv/priority_job_dispatcher_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the priority job dispatcher: clock, reset, command stimulus and verdict.
module priority_job_dispatcher_top_tb;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  pjd_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_stall;
  pjd_pkg::out_beat_t out_data;
  int                 fail_count;
  int                 pending_count;
  // When set, neither side idles; this gives a stretch of back-to-back traffic.
  bit                 no_idle;
  int                 quiet_cycles;
  bit                 timed_out;

  localparam int WATCHDOG_LIMIT = 20000;
  // Command code that the dispatcher does not use; it must answer with nothing happened.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  priority_job_dispatcher_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  pjd_result_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // The receiver stalls at random about 15 percent of the time, except in the quiet stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 15);
    end
  end

  // The watchdog counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL priority_job_dispatcher_top");
      $finish;
    end
  end

  // Sends one command beat: an optional random gap first, then valid held until accepted.
  // The payload is set at the same edge valid rises and stays put while stalled.
  task automatic send_beat(pjd_pkg::in_beat_t b);
    while (!no_idle && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      in_data <= pjd_pkg::in_beat_t'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_cmd(pjd_pkg::cmd_t c, logic [15:0] cust, logic [9:0] prep,
                          logic [9:0] route_len, logic [7:0] prio);
    pjd_pkg::in_beat_t b;
    b.command = c;
    b.customer_id = cust;
    b.prep_time = prep;
    b.distance = route_len;
    b.priority_req = prio;
    send_beat(b);
  endtask

  // Random job with mostly short work times so that ticks complete jobs often.
  task automatic send_random_add();
    logic [9:0] prep;
    logic [9:0] route_len;
    if ($urandom_range(9) == 0) begin
      prep = 10'($urandom);
      route_len = 10'($urandom);
    end else begin
      prep = 10'($urandom_range(3));
      route_len = 10'($urandom_range(2));
    end
    send_cmd(pjd_pkg::CMD_ADD, 16'($urandom), prep, route_len, 8'($urandom_range(7) * 37));
  endtask

  initial begin
    pjd_pkg::in_beat_t raw;
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    no_idle = 1'b0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: nothing to assign or complete, field extremes, equal priorities,
    // zero work time, a worker shortage and the unused command code.
    send_cmd(pjd_pkg::CMD_ASSIGN, '0, '0, '0, '0);
    send_cmd(pjd_pkg::CMD_TICK, '0, '0, '0, '0);
    send_cmd(pjd_pkg::CMD_ADD, 16'hFFFF, 10'h3FF, 10'h3FF, 8'hFF);
    send_cmd(pjd_pkg::CMD_ADD, 16'h0000, 10'd0, 10'd0, 8'h00);
    send_cmd(pjd_pkg::CMD_ADD, 16'h1234, 10'd0, 10'd1, 8'h80);
    send_cmd(pjd_pkg::CMD_ADD, 16'h4321, 10'd1, 10'd0, 8'h80);
    send_cmd(pjd_pkg::CMD_ADD, 16'hAAAA, 10'd0, 10'd0, 8'h80);
    send_cmd(pjd_pkg::CMD_ADD, 16'h5555, 10'd0, 10'd0, 8'h7F);
    send_cmd(pjd_pkg::CMD_ADD, 16'h0F0F, 10'd2, 10'd0, 8'h01);
    send_cmd(pjd_pkg::CMD_ASSIGN, '0, '0, '0, '0);
    send_cmd(pjd_pkg::CMD_ASSIGN, '0, '0, '0, '0);
    raw = '0;
    raw.command = CMD_SPARE;
    raw.customer_id = 16'hFFFF;
    raw.prep_time = 10'h3FF;
    raw.distance = 10'h3FF;
    raw.priority_req = 8'hFF;
    send_beat(raw);
    repeat (3) send_cmd(pjd_pkg::CMD_TICK, '0, '0, '0, '0);
    send_cmd(pjd_pkg::CMD_ASSIGN, '0, '0, '0, '0);
    repeat (3) send_cmd(pjd_pkg::CMD_TICK, '0, '0, '0, '0);

    // Random part: a quiet stretch first, then idling on both sides.
    no_idle = 1'b1;
    for (int n = 0; n < 60; n++) begin
      if (n == 40) no_idle = 1'b0;
      pick = $urandom_range(99);
      if (pick < 40) send_random_add();
      else if (pick < 60) send_cmd(pjd_pkg::CMD_ASSIGN, 16'($urandom), 10'($urandom),
                                   10'($urandom), 8'($urandom));
      else if (pick < 95) send_cmd(pjd_pkg::CMD_TICK, 16'($urandom), 10'($urandom),
                                   10'($urandom), 8'($urandom));
      else begin
        raw = pjd_pkg::in_beat_t'($urandom);
        raw.command = CMD_SPARE;
        send_beat(raw);
      end
    end

    // Fill the table to reach the table-full rejection, then drain some work.
    for (int n = 0; n < 110; n++) send_random_add();
    repeat (3) send_cmd(pjd_pkg::CMD_ADD, 16'($urandom), 10'($urandom), 10'($urandom),
                        8'($urandom));
    repeat (4) begin
      send_cmd(pjd_pkg::CMD_ASSIGN, '0, '0, '0, '0);
      repeat (4) send_cmd(pjd_pkg::CMD_TICK, '0, '0, '0, '0);
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS priority_job_dispatcher_top");
    end else begin
      $display("FAIL priority_job_dispatcher_top");
    end
    $finish;
  end
endmodule
